### rtl/core/oads_pkg.sv
// ---------------------------------------------------------------------------
// oads_pkg
// Shared types, register map and constants of the drive sequencer core.
// ---------------------------------------------------------------------------
package oads_pkg;

  // APB register map, 32-bit registers at 4*index
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_MM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_IS_OBST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_SPD         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REV_SPD         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_INNER      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_OUTER      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MS      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_MS         = 3'd7;

  typedef struct packed {
    logic [11:0] obstacle_mm;
    logic        timeout_is_obstacle;
    logic [7:0]  fwd_spd;
    logic [7:0]  rev_spd;
    logic [7:0]  inner_spd;
    logic [7:0]  outer_spd;
    logic [15:0] reverse_ms;
    logic [15:0] turn_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    obstacle_mm:         12'd200,
    timeout_is_obstacle: 1'b1,
    fwd_spd:             8'd100,
    rev_spd:             8'd80,
    inner_spd:           8'd45,
    outer_spd:           8'd120,
    reverse_ms:          16'd4000,
    turn_ms:             16'd1200
  };

  // request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_STEP   = 1'b1;

  typedef struct packed {
    logic        op;
    logic        left_level;
    logic        right_level;
    logic        echo_valid;
    logic [11:0] distance_mm;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] left_speed;
    logic       left_reverse;
    logic [7:0] right_speed;
    logic       right_reverse;
    logic [1:0] drive_phase;
    logic       turning_left;
  } out_item_t;

  // sequencer state, one-hot
  typedef enum logic [3:0] {
    PH_FWD  = 4'b0001,
    PH_STOP = 4'b0010,
    PH_REV  = 4'b0100,
    PH_TURN = 4'b1000
  } phase_t;

  // drive_phase codes on the result
  localparam logic [1:0] DP_FWD  = 2'd0;
  localparam logic [1:0] DP_STOP = 2'd1;
  localparam logic [1:0] DP_REV  = 2'd2;
  localparam logic [1:0] DP_TURN = 2'd3;

  localparam int          TRIGGER_SAMPLES_DEF = 2;
  localparam logic [15:0] STOP_MS     = 16'd200;
  localparam logic [15:0] REFRESH_MS  = 16'd200;
  localparam logic [7:0]  SPEED_CLAMP = 8'd150;

  // debounced line status and obstacle decision
  typedef struct packed {
    logic seen;
    logic bound_l;
    logic bound_r;
    logic obstacle;
  } sense_t;

  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_FWD:  code = DP_FWD;
      PH_STOP: code = DP_STOP;
      PH_REV:  code = DP_REV;
      PH_TURN: code = DP_TURN;
      default: code = DP_FWD;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/oads_cfg.sv
// ---------------------------------------------------------------------------
// oads_cfg
// APB register file holding the sequencer settings.
// ---------------------------------------------------------------------------
module oads_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [oads_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [oads_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [oads_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output oads_pkg::cfg_t                    cfg
);

  oads_pkg::cfg_t                   cfg_r;
  logic [oads_pkg::CFG_IDX_W-1:0]   idx;
  logic                             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[oads_pkg::CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= oads_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        oads_pkg::REG_OBSTACLE_MM:     cfg_r.obstacle_mm         <= pwdata[11:0];
        oads_pkg::REG_TIMEOUT_IS_OBST: cfg_r.timeout_is_obstacle <= pwdata[0];
        oads_pkg::REG_FWD_SPD:         cfg_r.fwd_spd             <= pwdata[7:0];
        oads_pkg::REG_REV_SPD:         cfg_r.rev_spd             <= pwdata[7:0];
        oads_pkg::REG_TURN_INNER:      cfg_r.inner_spd           <= pwdata[7:0];
        oads_pkg::REG_TURN_OUTER:      cfg_r.outer_spd           <= pwdata[7:0];
        oads_pkg::REG_REVERSE_MS:      cfg_r.reverse_ms          <= pwdata[15:0];
        oads_pkg::REG_TURN_MS:         cfg_r.turn_ms             <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      oads_pkg::REG_OBSTACLE_MM:     prdata[11:0] = cfg_r.obstacle_mm;
      oads_pkg::REG_TIMEOUT_IS_OBST: prdata[0]    = cfg_r.timeout_is_obstacle;
      oads_pkg::REG_FWD_SPD:         prdata[7:0]  = cfg_r.fwd_spd;
      oads_pkg::REG_REV_SPD:         prdata[7:0]  = cfg_r.rev_spd;
      oads_pkg::REG_TURN_INNER:      prdata[7:0]  = cfg_r.inner_spd;
      oads_pkg::REG_TURN_OUTER:      prdata[7:0]  = cfg_r.outer_spd;
      oads_pkg::REG_REVERSE_MS:      prdata[15:0] = cfg_r.reverse_ms;
      oads_pkg::REG_TURN_MS:         prdata[15:0] = cfg_r.turn_ms;
      default:                       prdata = '0;
    endcase
  end

endmodule

### rtl/core/oads_sense.sv
// ---------------------------------------------------------------------------
// oads_sense
// Line sensor debounce and latched echo reading.
// ---------------------------------------------------------------------------
module oads_sense #(
  parameter int TRIGGER_SAMPLES = oads_pkg::TRIGGER_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              sample_en,
  input  oads_pkg::in_item_t item,
  input  oads_pkg::cfg_t    cfg,
  output oads_pkg::sense_t  sense
);

  localparam int CNT_W = $clog2(TRIGGER_SAMPLES + 1);
  localparam logic [CNT_W-1:0] TRIG = CNT_W'(TRIGGER_SAMPLES);

  logic [CNT_W-1:0] left_cnt_r,  left_cnt_nxt;
  logic [CNT_W-1:0] right_cnt_r, right_cnt_nxt;
  logic             seen_r;
  logic             echo_ok_r;
  logic [11:0]      dist_r;

  // saturating count while over tape, cleared on a low level
  always_comb begin
    left_cnt_nxt  = '0;
    right_cnt_nxt = '0;
    if (item.left_level)
      left_cnt_nxt = (left_cnt_r < TRIG) ? left_cnt_r + 1'b1 : left_cnt_r;
    if (item.right_level)
      right_cnt_nxt = (right_cnt_r < TRIG) ? right_cnt_r + 1'b1 : right_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
      seen_r      <= 1'b0;
      echo_ok_r   <= 1'b0;
      dist_r      <= '0;
    end else if (sample_en) begin
      left_cnt_r  <= left_cnt_nxt;
      right_cnt_r <= right_cnt_nxt;
      seen_r      <= 1'b1;
      echo_ok_r   <= item.echo_valid;
      dist_r      <= item.distance_mm;
    end
  end

  assign sense.seen     = seen_r;
  assign sense.bound_l  = (left_cnt_r >= TRIG);
  assign sense.bound_r  = (right_cnt_r >= TRIG);
  assign sense.obstacle = echo_ok_r ? (dist_r <= cfg.obstacle_mm)
                                    : cfg.timeout_is_obstacle;

endmodule

### rtl/core/oads_seq.sv
// ---------------------------------------------------------------------------
// oads_seq
// Timed drive phase sequencer, wheel commands and send decision.
// ---------------------------------------------------------------------------
module oads_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [31:0]        now_ms,
  input  oads_pkg::sense_t   sense,
  input  oads_pkg::cfg_t     cfg,
  output logic               send,
  output oads_pkg::out_item_t res,
  output oads_pkg::phase_t   phase
);

  oads_pkg::phase_t phase_r, phase_nxt;
  logic             left_side_r, left_side_nxt;
  logic [31:0]      start_r, start_nxt;
  logic [31:0]      last_send_r;
  logic [8:0]       last_l_r, last_r_r;   // signed two's complement
  logic [8:0]       lcmd, rcmd;
  logic [31:0]      elapsed, since_send;
  logic [8:0]       l_abs, r_abs;

  assign elapsed    = now_ms - start_r;
  assign since_send = now_ms - last_send_r;

  always_comb begin
    phase_nxt     = phase_r;
    left_side_nxt = left_side_r;
    start_nxt     = start_r;
    if (sense.seen) begin
      case (phase_r)
        oads_pkg::PH_FWD: begin
          if (sense.bound_l || sense.bound_r) begin
            // single-side boundary turns away from it
            if (sense.bound_l && !sense.bound_r)      left_side_nxt = 1'b0;
            else if (sense.bound_r && !sense.bound_l) left_side_nxt = 1'b1;
            phase_nxt = oads_pkg::PH_STOP;
            start_nxt = now_ms;
          end else if (sense.obstacle) begin
            left_side_nxt = ~left_side_r;
            phase_nxt     = oads_pkg::PH_STOP;
            start_nxt     = now_ms;
          end
        end
        oads_pkg::PH_STOP: begin
          if (elapsed >= {16'd0, oads_pkg::STOP_MS}) begin
            phase_nxt = oads_pkg::PH_REV;
            start_nxt = now_ms;
          end
        end
        oads_pkg::PH_REV: begin
          if (elapsed >= {16'd0, cfg.reverse_ms}) begin
            phase_nxt = oads_pkg::PH_TURN;
            start_nxt = now_ms;
          end
        end
        oads_pkg::PH_TURN: begin
          if (elapsed >= {16'd0, cfg.turn_ms}) begin
            phase_nxt = oads_pkg::PH_FWD;
            start_nxt = now_ms;
          end
        end
        default: phase_nxt = oads_pkg::PH_FWD;
      endcase
    end
  end

  always_comb begin
    lcmd = '0;
    rcmd = '0;
    if (sense.seen) begin
      case (phase_nxt)
        oads_pkg::PH_FWD: begin
          lcmd = {1'b0, cfg.fwd_spd};
          rcmd = {1'b0, cfg.fwd_spd};
        end
        oads_pkg::PH_REV: begin
          lcmd = ~{1'b0, cfg.rev_spd} + 9'd1;
          rcmd = ~{1'b0, cfg.rev_spd} + 9'd1;
        end
        oads_pkg::PH_TURN: begin
          lcmd = {1'b0, left_side_nxt ? cfg.inner_spd : cfg.outer_spd};
          rcmd = {1'b0, left_side_nxt ? cfg.outer_spd : cfg.inner_spd};
        end
        default: begin
          lcmd = '0;
          rcmd = '0;
        end
      endcase
    end
  end

  assign send = (lcmd != last_l_r) || (rcmd != last_r_r) ||
                (since_send >= {16'd0, oads_pkg::REFRESH_MS});

  assign l_abs = lcmd[8] ? (~lcmd + 9'd1) : lcmd;
  assign r_abs = rcmd[8] ? (~rcmd + 9'd1) : rcmd;

  assign res.left_speed    = (l_abs > {1'b0, oads_pkg::SPEED_CLAMP}) ?
                             oads_pkg::SPEED_CLAMP : l_abs[7:0];
  assign res.left_reverse  = lcmd[8];
  assign res.right_speed   = (r_abs > {1'b0, oads_pkg::SPEED_CLAMP}) ?
                             oads_pkg::SPEED_CLAMP : r_abs[7:0];
  assign res.right_reverse = rcmd[8];
  assign res.drive_phase   = oads_pkg::phase_code(phase_nxt);
  assign res.turning_left  = left_side_nxt;

  assign phase = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= oads_pkg::PH_FWD;
      left_side_r <= 1'b0;
      start_r     <= '0;
      last_send_r <= '0;
      last_l_r    <= '0;
      last_r_r    <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      left_side_r <= left_side_nxt;
      start_r     <= start_nxt;
      if (send) begin
        last_l_r    <= lcmd;
        last_r_r    <= rcmd;
        last_send_r <= now_ms;
      end
    end
  end

endmodule

### rtl/core/obstacle_avoid_drive_sequencer_core.sv
// ---------------------------------------------------------------------------
// obstacle_avoid_drive_sequencer_core
// Obstacle and boundary avoiding drive sequencer with wheel command output.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : requests, valid/stall. op=0 is a sensor sample (line levels,
//           echo flag, distance), op=1 is a control step carrying now_ms.
//   out_* : one result per control step whose wheel commands changed or
//           whose refresh interval has run out; samples never give one.
//   APB   : eight 32-bit settings at byte address 4*index, writes in the
//           access cycle, pready tied high, reads return the setting.
// Timing:
//   A request is registered on acceptance, processed by the debounce and
//   sequencer logic, and its result lands in the output register, from
//   which it is offered. One request per cycle is sustained while out_stall
//   is low; the single output register sets it.
// Stall:
//   While out_stall holds a pending result, the request waiting in the
//   input register stalls and in_stall rises; nothing is dropped.
// Reset:
//   rst_n (synchronous) loads setting defaults, forward phase, right turn
//   side and clear counters; the sequencer holds with zero speeds until
//   the first sensor sample arrives.
// ---------------------------------------------------------------------------
module obstacle_avoid_drive_sequencer_core #(
  parameter int TRIGGER_SAMPLES = oads_pkg::TRIGGER_SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  oads_pkg::in_item_t               in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output oads_pkg::out_item_t              out_data,
  // APB settings port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [oads_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [oads_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [oads_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  oads_pkg::cfg_t      cfg;
  oads_pkg::sense_t    sense;
  oads_pkg::out_item_t res;
  oads_pkg::phase_t    phase;

  // input register
  logic                inq_valid_r;
  oads_pkg::in_item_t  inq_r;
  // output register
  logic                out_valid_r;
  oads_pkg::out_item_t out_r;

  logic advance;     // the held request is processed this cycle
  logic sample_en;
  logic step_en;
  logic send;

  // process when the output register is free or being emptied
  assign advance   = inq_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = inq_valid_r && out_valid_r && out_stall;
  assign sample_en = advance && (inq_r.op == oads_pkg::OP_SAMPLE);
  assign step_en   = advance && (inq_r.op == oads_pkg::OP_STEP);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  oads_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  oads_sense #(
    .TRIGGER_SAMPLES (TRIGGER_SAMPLES)
  ) u_sense (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .item      (inq_r),
    .cfg       (cfg),
    .sense     (sense)
  );

  oads_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .now_ms  (inq_r.now_ms),
    .sense   (sense),
    .cfg     (cfg),
    .send    (send),
    .res     (res),
    .phase   (phase)
  );

  // request register: refills whenever it is not held by a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (!in_stall) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      inq_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && send) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && send) begin
      out_r <= res;
    end
  end

  // a stalled input always has a request parked in the input register
  a_stall_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> inq_valid_r)
    else $error("input stall without held request");

  // a pending result is never overwritten while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(step_en && send))
    else $error("result overwritten under stall");

  // stop phase always commands zero speed
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.drive_phase == oads_pkg::DP_STOP)) |->
      (out_r.left_speed == 8'd0 && out_r.right_speed == 8'd0))
    else $error("nonzero speed in stop phase");

  // speed magnitudes respect the clamp
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.left_speed <= oads_pkg::SPEED_CLAMP &&
                     out_r.right_speed <= oads_pkg::SPEED_CLAMP))
    else $error("speed above clamp");

  // sequencer holds in forward phase until the first sample
  a_hold_unseen: assert property (@(posedge clk) disable iff (!rst_n)
    !sense.seen |-> (phase == oads_pkg::PH_FWD))
    else $error("sequencer moved before first sample");

endmodule
